[rtl/core/blpf_pkg.sv]
// Shared widths, mode and animation codes, and divider interface types.
package blpf_pkg;

	localparam int IN_TDATA_W  = 40;
	localparam int IN_TUSER_W  = 1;
	localparam int OUT_TDATA_W = 24;
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 16;
	localparam int DIV_NUM_W   = 32;
	localparam int DIV_DEN_W   = 16;
	localparam int DIV_CNT_W   = 6;

	localparam logic [1:0] MODE_DISABLED = 2'd0;
	localparam logic [1:0] MODE_GUIDANCE = 2'd1;
	localparam logic [1:0] MODE_LANDED   = 2'd2;

	localparam logic [1:0] ANIM_OFF   = 2'd0;
	localparam logic [1:0] ANIM_GUIDE = 2'd1;
	localparam logic [1:0] ANIM_FADE  = 2'd2;

	typedef struct packed {
		logic [DIV_DEN_W-1:0] rem_init;
		logic [DIV_NUM_W-1:0] num;
		logic [DIV_DEN_W-1:0] den;
		logic [DIV_CNT_W-1:0] count;
	} div_req_t;

	typedef struct packed {
		logic                 done;
		logic [DIV_NUM_W-1:0] quo;
		logic [DIV_DEN_W-1:0] rem;
	} div_rsp_t;

endpackage

[rtl/core/led_beacon_pulse_fade_controller.sv]
// Top level: item sequencer, beacon state and output register.
// Guidance scan (and a landed update while guiding): a 32-step modulo and an index divide on the
// shared divider; fade scan: two 16-step divides; every other item goes straight to the result.
// One item in flight; s_tready returns as the result enters the output register.
// arst_n clears the configuration to its defaults, the beacon state and the output valid.
module led_beacon_pulse_fade_controller #(
	parameter int SINE_TABLE_DEPTH = 256
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// new_mode[1:0], now_ms[33:2], zero[39:34]
	input  logic [blpf_pkg::IN_TDATA_W-1:0]   s_tdata,
	// op[0]
	input  logic [blpf_pkg::IN_TUSER_W-1:0]   s_tuser,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// pwm_a[7:0], pwm_b[15:8], drive_written[16], anim_state[18:17], mode_now[20:19], zero[23:21]
	output logic [blpf_pkg::OUT_TDATA_W-1:0]  m_tdata,
	input  logic                              cfg_wen,
	input  logic [blpf_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [blpf_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
	import blpf_pkg::*;

	localparam int IW = $clog2(SINE_TABLE_DEPTH);
	localparam int DW = $clog2(SINE_TABLE_DEPTH + 1);
	localparam int NW = 16 + DW;
	localparam logic [DW-1:0] DEPTH_C = DW'(SINE_TABLE_DEPTH);

	localparam logic OP_SCAN = 1'b0;

	localparam logic [CFG_INDEX_W-1:0] REG_ATTACHED = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_PERIOD   = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_FADE     = 2'd2;

	localparam logic [15:0] PERIOD_RESET = 16'd1200;
	localparam logic [15:0] FADE_RESET   = 16'd200;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_GMOD_GO,
		ST_GMOD_WAIT,
		ST_GIDX_GO,
		ST_GIDX_WAIT,
		ST_FA_GO,
		ST_FA_WAIT,
		ST_FB_GO,
		ST_FB_WAIT,
		ST_DONE
	} state_t;

	function automatic logic [7:0] duty_pwm(input logic [15:0] d);
		logic [23:0] t;
		t = {d, 8'd0} - {8'd0, d} + 24'd255;
		return t[23:16];
	endfunction

	state_t      state_q;
	logic        attached_q;
	logic [15:0] period_q;
	logic [15:0] fade_q;
	logic [1:0]  anim_q;
	logic [1:0]  mode_q;
	logic [31:0] gstart_q;
	logic [31:0] fstart_q;
	logic [15:0] duty_a_q;
	logic [15:0] duty_b_q;
	logic [15:0] from_a_q;
	logic [15:0] from_b_q;
	logic [31:0] now_q;
	logic [31:0] elapsed_q;
	logic [15:0] frac_q;
	logic [15:0] remain_q;
	logic        land_q;
	logic        side_a_q;
	logic        wrote_q;
	logic        m_valid_q;
	logic [20:0] m_data_q;

	logic        in_fire;
	logic        in_op;
	logic [1:0]  in_mode;
	logic [31:0] in_now;
	logic [15:0] per_w;
	logic [15:0] len_w;
	logic [31:0] fade_elapsed;
	logic        fade_over;
	logic        go_guide;
	logic        go_fade;
	logic        idle_wrote;
	logic [16:0] twice_p;
	logic        a_half;
	logic [15:0] frac_w;
	logic [NW-1:0] prod_idx;
	logic [31:0] prod_fade;
	logic [15:0] from_sel;
	logic        div_go;
	div_req_t    div_req;
	div_rsp_t    div_rsp;
	logic [15:0] sine_val;
	logic        out_free;

	assign s_tready = (state_q == ST_IDLE);
	assign in_fire  = s_tvalid && s_tready;
	assign in_op    = s_tuser[0];
	assign in_mode  = s_tdata[1:0];
	assign in_now   = s_tdata[33:2];

	assign per_w        = (period_q < 16'd2) ? 16'd2 : period_q;
	assign len_w        = (fade_q == 16'd0) ? 16'd1 : fade_q;
	assign fade_elapsed = in_now - fstart_q;
	assign fade_over    = fade_elapsed >= {16'd0, len_w};

	assign go_guide   = attached_q && (anim_q == ANIM_GUIDE) &&
		((in_op == OP_SCAN) || (in_mode == MODE_LANDED));
	assign go_fade    = attached_q && (in_op == OP_SCAN) && (anim_q == ANIM_FADE) && !fade_over;
	assign idle_wrote = attached_q && ((in_op == OP_SCAN) ?
		((anim_q == ANIM_FADE) && fade_over) :
		((in_mode != MODE_GUIDANCE) && ((in_mode != MODE_LANDED) ||
			((anim_q != ANIM_GUIDE) && (anim_q != ANIM_FADE)))));

	assign twice_p = {div_rsp.rem, 1'b0};
	assign a_half  = twice_p < {1'b0, per_w};
	assign frac_w  = a_half ? twice_p[15:0] : 16'(twice_p - {1'b0, per_w});

	assign prod_idx  = NW'(frac_q) * NW'(DEPTH_C);
	assign from_sel  = (state_q == ST_FA_GO) ? from_a_q : from_b_q;
	assign prod_fade = {16'd0, from_sel} * {16'd0, remain_q};

	always_comb begin
		div_go  = 1'b0;
		div_req = '0;
		case (state_q)
			ST_GMOD_GO: begin
				div_go  = 1'b1;
				div_req = '{rem_init: 16'd0, num: elapsed_q, den: per_w,
					count: DIV_CNT_W'(DIV_NUM_W)};
			end
			ST_GIDX_GO: begin
				div_go  = 1'b1;
				div_req = '{rem_init: 16'(prod_idx >> IW),
					num: {prod_idx[IW-1:0], {(DIV_NUM_W-IW){1'b0}}},
					den: per_w, count: DIV_CNT_W'(IW)};
			end
			ST_FA_GO, ST_FB_GO: begin
				div_go  = 1'b1;
				div_req = '{rem_init: prod_fade[31:16], num: {prod_fade[15:0], 16'd0},
					den: len_w, count: DIV_CNT_W'(16)};
			end
			default: begin
				div_go  = 1'b0;
			end
		endcase
	end

	blpf_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_go),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	blpf_sine #(
		.DEPTH (SINE_TABLE_DEPTH)
	) u_sine (
		.idx (div_rsp.quo[IW-1:0]),
		.val (sine_val)
	);

	assign out_free = !m_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			attached_q <= 1'b0;
			period_q   <= PERIOD_RESET;
			fade_q     <= FADE_RESET;
			anim_q     <= ANIM_OFF;
			mode_q     <= MODE_DISABLED;
			gstart_q   <= '0;
			fstart_q   <= '0;
			duty_a_q   <= '0;
			duty_b_q   <= '0;
			from_a_q   <= '0;
			from_b_q   <= '0;
			land_q     <= 1'b0;
			wrote_q    <= 1'b0;
			m_valid_q  <= 1'b0;
		end else begin
			if (m_valid_q && m_tready && (state_q != ST_DONE)) begin
				m_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						wrote_q <= idle_wrote;
						land_q  <= (in_op != OP_SCAN);
						if (go_guide) begin
							state_q <= ST_GMOD_GO;
						end else if (go_fade) begin
							state_q <= ST_FA_GO;
						end else begin
							state_q <= ST_DONE;
						end
						if (attached_q) begin
							if (in_op == OP_SCAN) begin
								if (anim_q == ANIM_FADE && fade_over) begin
									anim_q   <= ANIM_OFF;
									duty_a_q <= '0;
									duty_b_q <= '0;
								end
							end else begin
								case (in_mode)
									MODE_GUIDANCE: begin
										gstart_q <= in_now;
										mode_q   <= MODE_GUIDANCE;
										anim_q   <= ANIM_GUIDE;
									end
									MODE_LANDED: begin
										mode_q <= MODE_LANDED;
										if (anim_q != ANIM_GUIDE && anim_q != ANIM_FADE) begin
											anim_q   <= ANIM_OFF;
											duty_a_q <= '0;
											duty_b_q <= '0;
										end
									end
									default: begin
										mode_q   <= MODE_DISABLED;
										anim_q   <= ANIM_OFF;
										duty_a_q <= '0;
										duty_b_q <= '0;
									end
								endcase
							end
						end
					end else if (cfg_wen) begin
						case (cfg_index)
							REG_ATTACHED: begin
								attached_q <= cfg_wdata[0];
								anim_q     <= ANIM_OFF;
								mode_q     <= MODE_DISABLED;
								gstart_q   <= '0;
								fstart_q   <= '0;
								duty_a_q   <= '0;
								duty_b_q   <= '0;
								from_a_q   <= '0;
								from_b_q   <= '0;
							end
							REG_PERIOD: begin
								period_q <= cfg_wdata;
							end
							REG_FADE: begin
								fade_q <= cfg_wdata;
							end
							default: begin
								period_q <= period_q;
							end
						endcase
					end
				end
				ST_GMOD_GO: begin
					state_q <= ST_GMOD_WAIT;
				end
				ST_GMOD_WAIT: begin
					if (div_rsp.done) begin
						state_q <= ST_GIDX_GO;
					end
				end
				ST_GIDX_GO: begin
					state_q <= ST_GIDX_WAIT;
				end
				ST_GIDX_WAIT: begin
					if (div_rsp.done) begin
						duty_a_q <= side_a_q ? sine_val : 16'd0;
						duty_b_q <= side_a_q ? 16'd0 : sine_val;
						wrote_q  <= 1'b1;
						if (land_q) begin
							fstart_q <= now_q;
							from_a_q <= side_a_q ? sine_val : 16'd0;
							from_b_q <= side_a_q ? 16'd0 : sine_val;
							anim_q   <= (sine_val == 16'd0) ? ANIM_OFF : ANIM_FADE;
						end
						state_q <= ST_DONE;
					end
				end
				ST_FA_GO: begin
					state_q <= ST_FA_WAIT;
				end
				ST_FA_WAIT: begin
					if (div_rsp.done) begin
						duty_a_q <= div_rsp.quo[15:0];
						state_q  <= ST_FB_GO;
					end
				end
				ST_FB_GO: begin
					state_q <= ST_FB_WAIT;
				end
				ST_FB_WAIT: begin
					if (div_rsp.done) begin
						duty_b_q <= div_rsp.quo[15:0];
						wrote_q  <= 1'b1;
						state_q  <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						m_valid_q <= 1'b1;
						state_q   <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			now_q     <= in_now;
			elapsed_q <= in_now - gstart_q;
			remain_q  <= len_w - fade_elapsed[15:0];
		end
		if (state_q == ST_GMOD_WAIT && div_rsp.done) begin
			frac_q   <= frac_w;
			side_a_q <= a_half;
		end
		if (state_q == ST_DONE && out_free) begin
			m_data_q <= {mode_q, anim_q, wrote_q, duty_pwm(duty_b_q), duty_pwm(duty_a_q)};
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {{(OUT_TDATA_W-21){1'b0}}, m_data_q};

endmodule

[rtl/core/blpf_div.sv]
// Shared restoring divider, one quotient bit per cycle.
module blpf_div (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  blpf_pkg::div_req_t req,
	output blpf_pkg::div_rsp_t rsp
);
	import blpf_pkg::*;

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DIV_DEN_W-1:0] r_q;
	logic [DIV_NUM_W-1:0] q_q;
	logic [DIV_DEN_W-1:0] d_q;

	logic [DIV_DEN_W:0] trial;
	logic [DIV_DEN_W:0] diff;
	logic               ge;

	assign trial = {r_q, q_q[DIV_NUM_W-1]};
	assign ge    = trial >= {1'b0, d_q};
	assign diff  = trial - {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && !start && (cnt_q == DIV_CNT_W'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= req.count;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			r_q <= req.rem_init;
			q_q <= req.num;
			d_q <= req.den;
		end else if (busy_q) begin
			r_q <= ge ? diff[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
			q_q <= {q_q[DIV_NUM_W-2:0], ge};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = q_q;
	assign rsp.rem  = r_q;

endmodule

[rtl/core/blpf_sine.sv]
// Half-sine duty table built at elaboration from a fixed-point Taylor series.
module blpf_sine #(
	parameter int DEPTH = 256
) (
	input  logic [$clog2(DEPTH)-1:0] idx,
	output logic [15:0]              val
);
	import blpf_pkg::*;

	localparam logic [63:0] PI_Q30    = 64'd3373259426;
	localparam logic [63:0] DUTY_FULL = 64'd65535;

	function automatic logic [15:0] half_sine(input int unsigned i);
		int unsigned j;
		logic [63:0] x;
		logic [63:0] term;
		logic [63:0] v;
		longint      sum;
		j = i;
		if (j > DEPTH - j) begin
			j = DEPTH - j;
		end
		x    = (PI_Q30 * 64'(j)) / 64'(DEPTH);
		term = x;
		sum  = longint'(x);
		term = (((term * x) >> 30) * x) >> 30;
		term = term / 64'd6;
		sum  = sum - longint'(term);
		term = (((term * x) >> 30) * x) >> 30;
		term = term / 64'd20;
		sum  = sum + longint'(term);
		term = (((term * x) >> 30) * x) >> 30;
		term = term / 64'd42;
		sum  = sum - longint'(term);
		term = (((term * x) >> 30) * x) >> 30;
		term = term / 64'd72;
		sum  = sum + longint'(term);
		term = (((term * x) >> 30) * x) >> 30;
		term = term / 64'd110;
		sum  = sum - longint'(term);
		if (sum < 0) begin
			return 16'd0;
		end
		v = (64'(sum) * DUTY_FULL + (64'd1 << 29)) >> 30;
		if (v > DUTY_FULL) begin
			v = DUTY_FULL;
		end
		return v[15:0];
	endfunction

	logic [15:0] tab [DEPTH];

	for (genvar g = 0; g < DEPTH; g++) begin : g_tab
		assign tab[g] = half_sine(g);
	end

	assign val = tab[idx];

endmodule

[rtl/core/blpf_checker.sv]
// Port-level checker for the beacon controller, bound to the top level.
module blpf_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             s_tvalid,
	input logic                             s_tready,
	input logic                             m_tvalid,
	input logic                             m_tready,
	input logic [blpf_pkg::OUT_TDATA_W-1:0] m_tdata
);
	import blpf_pkg::*;

	logic [7:0] pwm_a;
	logic [7:0] pwm_b;
	logic [1:0] anim;
	logic [1:0] mode;

	assign pwm_a = m_tdata[7:0];
	assign pwm_b = m_tdata[15:8];
	assign anim  = m_tdata[18:17];
	assign mode  = m_tdata[20:19];

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken again right after a transfer");

	a_fade_means_landed: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && anim == ANIM_FADE |-> mode == MODE_LANDED)
		else $error("fade shown outside landed mode");

	a_guide_means_guidance: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && anim == ANIM_GUIDE |-> mode == MODE_GUIDANCE)
		else $error("guidance animation shown outside guidance mode");

	a_off_is_dark: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && anim == ANIM_OFF |-> pwm_a == 8'd0 && pwm_b == 8'd0)
		else $error("nonzero PWM while animation is off");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled result changed or dropped");

endmodule

bind led_beacon_pulse_fade_controller blpf_checker u_blpf_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
